// ===== sv/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants for the bilinear texture sampler
// Channel, texel and weight types, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    // Fixed field widths
    localparam int CHAN_W     = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int INDEX_W    = 16;
    localparam int COORD_W    = 18;
    localparam int WEIGHT_W   = 17;
    localparam int CORNERS    = 4;

    // Command codes on func
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEX_HEIGHT = 2'd1;

    // Reset value of both dimension registers
    localparam logic [CFG_W-1:0] TEX_DIM_RESET = 9'd256;

    // Full-scale fraction weight (1.0 in 8 fraction bits)
    localparam logic [8:0] FRAC_ONE = 9'd256;

    // Rounding constant for a weight product with 16 fraction bits
    localparam int ROUND_HALF = 32768;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    // Corner order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    typedef weight_t [CORNERS-1:0] weight_set_t;
    typedef chan_t [CORNERS-1:0] corner_set_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } texel_t;

endpackage

`default_nettype wire

// ===== sv/bts_tex_ram.sv =====
// ----------------------------------------------------------------------------
// bts_tex_ram: texel memory bank
// One write port and two read ports, read data registered. No reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_tex_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire bts_pkg::texel_t wdata,
    input  wire logic [AW-1:0]   raddr_a,
    input  wire logic [AW-1:0]   raddr_b,
    output bts_pkg::texel_t      rdata_a,
    output bts_pkg::texel_t      rdata_b
);
    import bts_pkg::*;

    texel_t mem [DEPTH];
    texel_t rdata_a_reg;
    texel_t rdata_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered reads; a read at the written address returns the old entry
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== sv/bts_blend_lane.sv =====
// ----------------------------------------------------------------------------
// bts_blend_lane: one color channel of the bilinear blend
// Stage A multiplies the four corner bytes by their weights, stage B sums,
// rounds half up and keeps the 8-bit color.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_blend_lane (
    input  wire logic                 clk,
    input  wire bts_pkg::corner_set_t corner,
    input  wire bts_pkg::weight_set_t weight,
    output bts_pkg::chan_t            color
);
    import bts_pkg::*;

    localparam int PROD_W = WEIGHT_W + CHAN_W;
    localparam int SUM_W  = PROD_W + 2;

    logic [PROD_W-1:0] prod_reg [CORNERS];
    logic [PROD_W-1:0] prod_next [CORNERS];
    logic [SUM_W-1:0]  sum;
    chan_t             color_reg;
    chan_t             color_next;

    // Per-corner weighted products
    always_comb
    begin
        for (int i = 0; i < CORNERS; i++)
        begin
            prod_next[i] = PROD_W'(weight[i]) * PROD_W'(corner[i]);
        end
    end

    // Sum and round half up
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + SUM_W'(prod_reg[3]) + SUM_W'(ROUND_HALF);
        color_next = sum[23:16];
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        color_reg <= color_next;
    end

    assign color = color_reg;

endmodule

`default_nettype wire

// ===== sv/bilinear_texture_sampler_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top: bilinear texture sampler
// Loads RGB texels into a row-major store and answers bilinear samples.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. busy stays low, so one item can transfer every cycle. func
//   selects a texel load (texel_index and texel bytes) or a sample
//   (u_coord, v_coord, signed fixed point).
//   Result channel: each sample gives one color on red/green/blue with done
//   high for exactly one cycle; loads give nothing. The receiver cannot
//   stall, results are never held.
//   Throughput is one item per cycle, set by the seven-stage pipeline
//   and the two dual-read texel banks that supply all four corners in
//   one access.
//   A load writes the store from its stage 4 registers, in the same edge
//   at which samples read, so loads and samples keep their order.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write tex_width (index 0) or
//   tex_height (index 1) while the pipeline is empty.
//   Reset: clears the pipeline and sets both dimensions to 256. The texel
//   store is not cleared; read only entries that were loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler_top #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               func,
    input  wire logic [bts_pkg::INDEX_W-1:0]        texel_index,
    input  wire logic [bts_pkg::CHAN_W-1:0]         texel_red,
    input  wire logic [bts_pkg::CHAN_W-1:0]         texel_green,
    input  wire logic [bts_pkg::CHAN_W-1:0]         texel_blue,
    input  wire logic signed [bts_pkg::COORD_W-1:0] u_coord,
    input  wire logic signed [bts_pkg::COORD_W-1:0] v_coord,
    input  wire logic                               cfg_we,
    input  wire logic [bts_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bts_pkg::CFG_W-1:0]          cfg_wdata,
    output logic                                    done,
    output logic [bts_pkg::CHAN_W-1:0]              red,
    output logic [bts_pkg::CHAN_W-1:0]              green,
    output logic [bts_pkg::CHAN_W-1:0]              blue
);
    import bts_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WDW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = COORD_FRAC_BITS + 1;
    localparam int XSW   = CW + XW;
    localparam int YSW   = CW + YW;
    localparam int RW    = YW + WDW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ONE   = 1 << COORD_FRAC_BITS;
    localparam int FB    = COORD_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] tex_width_reg;
    logic [CFG_W-1:0] tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= TEX_DIM_RESET;
            tex_height_reg <= TEX_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits per stage
    // ------------------------------------------------------------------
    logic       accept;
    logic [7:1] smp_vld_reg;
    logic [7:1] smp_vld_next;
    logic [4:1] ld_vld_reg;
    logic [4:1] ld_vld_next;
    logic       ld_in_range;

    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign ld_in_range = 32'(texel_index) < DEPTH;

    always_comb
    begin
        smp_vld_next    = {smp_vld_reg[6:1], accept && (func == FUNC_SAMPLE)};
        ld_vld_next     = {ld_vld_reg[3:1], accept && (func == FUNC_LOAD) && ld_in_range};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= '0;
            ld_vld_reg  <= '0;
        end
        else
        begin
            smp_vld_reg <= smp_vld_next;
            ld_vld_reg  <= ld_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp dimensions and coordinates
    // ------------------------------------------------------------------
    logic [WDW-1:0] w_clamp;
    logic [HDW-1:0] h_clamp;
    logic [CW-1:0]  cu_next;
    logic [CW-1:0]  cv_next;

    always_comb
    begin
        if (tex_width_reg == '0)
            w_clamp = WDW'(1);
        else if (32'(tex_width_reg) > MAX_WIDTH)
            w_clamp = WDW'(MAX_WIDTH);
        else
            w_clamp = WDW'(tex_width_reg);

        if (tex_height_reg == '0)
            h_clamp = HDW'(1);
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            h_clamp = HDW'(MAX_HEIGHT);
        else
            h_clamp = HDW'(tex_height_reg);

        if (u_coord[COORD_W-1])
            cu_next = '0;
        else if (32'(u_coord[COORD_W-2:0]) > ONE)
            cu_next = CW'(ONE);
        else
            cu_next = CW'(u_coord[COORD_W-2:0]);

        if (v_coord[COORD_W-1])
            cv_next = '0;
        else if (32'(v_coord[COORD_W-2:0]) > ONE)
            cv_next = CW'(ONE);
        else
            cv_next = CW'(v_coord[COORD_W-2:0]);
    end

    logic [CW-1:0]  s1_cu_reg;
    logic [CW-1:0]  s1_cv_reg;
    logic [WDW-1:0] s1_w_reg;
    logic [XW-1:0]  s1_wm1_reg;
    logic [YW-1:0]  s1_hm1_reg;
    logic [AW-1:0]  s1_ld_addr_reg;
    texel_t         s1_ld_data_reg;

    always_ff @(posedge clk)
    begin
        s1_cu_reg      <= cu_next;
        s1_cv_reg      <= cv_next;
        s1_w_reg       <= w_clamp;
        s1_wm1_reg     <= XW'(w_clamp - WDW'(1));
        s1_hm1_reg     <= YW'(h_clamp - HDW'(1));
        s1_ld_addr_reg <= AW'(texel_index);
        s1_ld_data_reg <= '{red: texel_red, green: texel_green, blue: texel_blue};
    end

    // ------------------------------------------------------------------
    // Stage 2: scale coordinates by dimension minus one
    // ------------------------------------------------------------------
    logic [XSW-1:0] s2_xs_reg;
    logic [YSW-1:0] s2_ys_reg;
    logic [WDW-1:0] s2_w_reg;
    logic [XW-1:0]  s2_wm1_reg;
    logic [YW-1:0]  s2_hm1_reg;
    logic [AW-1:0]  s2_ld_addr_reg;
    texel_t         s2_ld_data_reg;

    always_ff @(posedge clk)
    begin
        s2_xs_reg      <= XSW'(s1_cu_reg) * XSW'(s1_wm1_reg);
        s2_ys_reg      <= YSW'(s1_cv_reg) * YSW'(s1_hm1_reg);
        s2_w_reg       <= s1_w_reg;
        s2_wm1_reg     <= s1_wm1_reg;
        s2_hm1_reg     <= s1_hm1_reg;
        s2_ld_addr_reg <= s1_ld_addr_reg;
        s2_ld_data_reg <= s1_ld_data_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: integer parts, 8-bit fractions, far corners
    // ------------------------------------------------------------------
    logic [XW-1:0] xi;
    logic [YW-1:0] yi;
    logic [XW-1:0] x0_next;
    logic [XW-1:0] x1_next;
    logic [YW-1:0] y0_next;
    logic [YW-1:0] y1_next;

    always_comb
    begin
        xi      = s2_xs_reg[FB+XW-1:FB];
        yi      = s2_ys_reg[FB+YW-1:FB];
        x0_next = (xi > s2_wm1_reg) ? s2_wm1_reg : xi;
        y0_next = (yi > s2_hm1_reg) ? s2_hm1_reg : yi;
        x1_next = (x0_next < s2_wm1_reg) ? x0_next + XW'(1) : s2_wm1_reg;
        y1_next = (y0_next < s2_hm1_reg) ? y0_next + YW'(1) : s2_hm1_reg;
    end

    logic [XW-1:0]  s3_x0_reg;
    logic [XW-1:0]  s3_x1_reg;
    logic [YW-1:0]  s3_y0_reg;
    logic [YW-1:0]  s3_y1_reg;
    logic [7:0]     s3_s_reg;
    logic [7:0]     s3_t_reg;
    logic [WDW-1:0] s3_w_reg;
    logic [AW-1:0]  s3_ld_addr_reg;
    texel_t         s3_ld_data_reg;

    always_ff @(posedge clk)
    begin
        s3_x0_reg      <= x0_next;
        s3_x1_reg      <= x1_next;
        s3_y0_reg      <= y0_next;
        s3_y1_reg      <= y1_next;
        s3_s_reg       <= s2_xs_reg[FB-1:FB-8];
        s3_t_reg       <= s2_ys_reg[FB-1:FB-8];
        s3_w_reg       <= s2_w_reg;
        s3_ld_addr_reg <= s2_ld_addr_reg;
        s3_ld_data_reg <= s2_ld_data_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: row offsets and corner weights
    // ------------------------------------------------------------------
    logic [8:0]  is_w;
    logic [8:0]  it_w;
    weight_set_t wt_next;

    always_comb
    begin
        is_w       = FRAC_ONE - {1'b0, s3_s_reg};
        it_w       = FRAC_ONE - {1'b0, s3_t_reg};
        wt_next[0] = WEIGHT_W'(18'(is_w) * 18'(it_w));
        wt_next[1] = WEIGHT_W'(18'(s3_s_reg) * 18'(it_w));
        wt_next[2] = WEIGHT_W'(18'(is_w) * 18'(s3_t_reg));
        wt_next[3] = WEIGHT_W'(18'(s3_s_reg) * 18'(s3_t_reg));
    end

    logic [RW-1:0] s4_row0_reg;
    logic [RW-1:0] s4_row1_reg;
    logic [XW-1:0] s4_x0_reg;
    logic [XW-1:0] s4_x1_reg;
    weight_set_t   s4_wt_reg;
    logic [AW-1:0] s4_ld_addr_reg;
    texel_t        s4_ld_data_reg;

    always_ff @(posedge clk)
    begin
        s4_row0_reg    <= RW'(s3_y0_reg) * RW'(s3_w_reg);
        s4_row1_reg    <= RW'(s3_y1_reg) * RW'(s3_w_reg);
        s4_x0_reg      <= s3_x0_reg;
        s4_x1_reg      <= s3_x1_reg;
        s4_wt_reg      <= wt_next;
        s4_ld_addr_reg <= s3_ld_addr_reg;
        s4_ld_data_reg <= s3_ld_data_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: texel reads; loads write in the same edge
    // ------------------------------------------------------------------
    logic [AW-1:0] addr00;
    logic [AW-1:0] addr10;
    logic [AW-1:0] addr01;
    logic [AW-1:0] addr11;
    texel_t        c00;
    texel_t        c10;
    texel_t        c01;
    texel_t        c11;

    assign addr00 = AW'(s4_row0_reg + RW'(s4_x0_reg));
    assign addr10 = AW'(s4_row0_reg + RW'(s4_x1_reg));
    assign addr01 = AW'(s4_row1_reg + RW'(s4_x0_reg));
    assign addr11 = AW'(s4_row1_reg + RW'(s4_x1_reg));

    // Bank for the near row
    bts_tex_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_row0 (
        .clk     (clk),
        .we      (ld_vld_reg[4]),
        .waddr   (s4_ld_addr_reg),
        .wdata   (s4_ld_data_reg),
        .raddr_a (addr00),
        .raddr_b (addr10),
        .rdata_a (c00),
        .rdata_b (c10)
    );

    // Bank for the far row
    bts_tex_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_row1 (
        .clk     (clk),
        .we      (ld_vld_reg[4]),
        .waddr   (s4_ld_addr_reg),
        .wdata   (s4_ld_data_reg),
        .raddr_a (addr01),
        .raddr_b (addr11),
        .rdata_a (c01),
        .rdata_b (c11)
    );

    weight_set_t s5_wt_reg;

    always_ff @(posedge clk)
    begin
        s5_wt_reg <= s4_wt_reg;
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: per-channel blend
    // ------------------------------------------------------------------
    corner_set_t red_corner;
    corner_set_t green_corner;
    corner_set_t blue_corner;

    assign red_corner   = {c11.red,   c01.red,   c10.red,   c00.red};
    assign green_corner = {c11.green, c01.green, c10.green, c00.green};
    assign blue_corner  = {c11.blue,  c01.blue,  c10.blue,  c00.blue};

    bts_blend_lane u_lane_red (
        .clk    (clk),
        .corner (red_corner),
        .weight (s5_wt_reg),
        .color  (red)
    );

    bts_blend_lane u_lane_green (
        .clk    (clk),
        .corner (green_corner),
        .weight (s5_wt_reg),
        .color  (green)
    );

    bts_blend_lane u_lane_blue (
        .clk    (clk),
        .corner (blue_corner),
        .weight (s5_wt_reg),
        .color  (blue)
    );

    assign done = smp_vld_reg[7];

endmodule

`default_nettype wire

// ===== tb/sv/tb_bilinear_texture_sampler_top.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_texture_sampler_top: self-checking bench for the texture sampler
// Drives texel loads and bilinear samples through the command port and
// predicts every color from a local copy of the texel store. Texels are
// loaded on demand so that no sample touches an unloaded entry. Directed
// edge cases come first, then random traffic over many texture sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bilinear_texture_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int PIPE_LATENCY  = 7;
    localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int MAX_REPORTS   = 60;
    localparam int DIM_LIMIT_W   = 256;
    localparam int DIM_LIMIT_H   = 256;
    localparam int STORE_DEPTH   = DIM_LIMIT_W * DIM_LIMIT_H;
    localparam int COORD_ONE     = 1 << 16;

    // Register slots past the defined ones; writes there must have no effect
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

    // Four texel indexes of one sample plus the 8-bit blend fractions
    typedef struct packed {
        logic [CORNERS-1:0][INDEX_W-1:0] idx;
        logic [7:0]                      s;
        logic [7:0]                      t;
    } footprint_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      func;
    logic [INDEX_W-1:0]        texel_index;
    chan_t                     texel_red;
    chan_t                     texel_green;
    chan_t                     texel_blue;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      done;
    chan_t                     red;
    chan_t                     green;
    chan_t                     blue;

    // Local copy of the block state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    texel_t           texel_mem [STORE_DEPTH];
    bit               texel_loaded [STORE_DEPTH];

    texel_t expected_colors [$];
    int     error_count;
    int     item_count;

    bilinear_texture_sampler_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .texel_index (texel_index),
        .texel_red   (texel_red),
        .texel_green (texel_green),
        .texel_blue  (texel_blue),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------

    // Dimension as used: zero reads as one, oversize reads as the limit
    function automatic int used_dim(logic [CFG_W-1:0] d, int limit);
        if (d == 0)
            return 1;
        if (d > limit)
            return limit;
        return d;
    endfunction

    // Clamp to [0, 1.0] in 16 fraction bits
    function automatic int clamp_coord(logic signed [COORD_W-1:0] c);
        if (c < 0)
            return 0;
        if (c > COORD_ONE)
            return COORD_ONE;
        return int'(c);
    endfunction

    function automatic footprint_t locate_footprint(logic signed [COORD_W-1:0] u,
                                                    logic signed [COORD_W-1:0] v);
        footprint_t fp;
        int w, h, scaled_u, scaled_v, x0, x1, y0, y1;
        w = used_dim(width_reg, DIM_LIMIT_W);
        h = used_dim(height_reg, DIM_LIMIT_H);
        scaled_u = clamp_coord(u) * (w - 1);
        scaled_v = clamp_coord(v) * (h - 1);
        x0 = scaled_u >> 16;
        y0 = scaled_v >> 16;
        fp.s = 8'(scaled_u >> 8);
        fp.t = 8'(scaled_v >> 8);
        // far corner held to the last column / row
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        fp.idx[0] = INDEX_W'(x0 + y0 * w);
        fp.idx[1] = INDEX_W'(x1 + y0 * w);
        fp.idx[2] = INDEX_W'(x0 + y1 * w);
        fp.idx[3] = INDEX_W'(x1 + y1 * w);
        return fp;
    endfunction

    // Weighted sum of four channel values, rounded half up
    function automatic chan_t blend_chan(chan_t a, chan_t b, chan_t c, chan_t d,
                                         int s, int t);
        int sum;
        sum = (256 - s) * (256 - t) * int'(a) + s * (256 - t) * int'(b)
            + (256 - s) * t * int'(c) + s * t * int'(d);
        return chan_t'((sum + ROUND_HALF) >> 16);
    endfunction

    function automatic texel_t predict_color(logic signed [COORD_W-1:0] u,
                                             logic signed [COORD_W-1:0] v);
        footprint_t fp;
        texel_t c00, c10, c01, c11, color;
        fp = locate_footprint(u, v);
        c00 = texel_mem[fp.idx[0]];
        c10 = texel_mem[fp.idx[1]];
        c01 = texel_mem[fp.idx[2]];
        c11 = texel_mem[fp.idx[3]];
        color.red   = blend_chan(c00.red, c10.red, c01.red, c11.red, fp.s, fp.t);
        color.green = blend_chan(c00.green, c10.green, c01.green, c11.green, fp.s, fp.t);
        color.blue  = blend_chan(c00.blue, c10.blue, c01.blue, c11.blue, fp.s, fp.t);
        return color;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic texel_t random_texel();
        logic [23:0] bits;
        bits = 24'($urandom);
        return bits;
    endfunction

    // Mostly in range, some exact edges, the rest anywhere in 18 bits
    function automatic logic signed [COORD_W-1:0] random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return COORD_W'($urandom_range(0, COORD_ONE));
        if (r < 65)
            return ($urandom_range(0, 1) == 0) ? COORD_W'(0) : COORD_W'(COORD_ONE);
        return COORD_W'($urandom);
    endfunction

    // Mostly short gaps, a few long ones, none in burst mode
    function automatic int random_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // One command transfer; the local model follows at the transfer edge
    task automatic send_item(input logic f, input logic [INDEX_W-1:0] idx,
                             input texel_t tx, input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v);
        @(negedge clk);
        start       <= 1'b1;
        func        <= f;
        texel_index <= idx;
        texel_red   <= tx.red;
        texel_green <= tx.green;
        texel_blue  <= tx.blue;
        u_coord     <= u;
        v_coord     <= v;
        do
            @(posedge clk);
        while (busy);
        item_count++;
        if (f == FUNC_LOAD)
        begin
            texel_mem[idx]    = tx;
            texel_loaded[idx] = 1'b1;
        end
        else
            expected_colors.push_back(predict_color(u, v));
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input texel_t tx);
        send_item(FUNC_LOAD, idx, tx, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Any unloaded corner gets a random texel first
    task automatic send_sample(input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v);
        footprint_t fp;
        fp = locate_footprint(u, v);
        for (int k = 0; k < CORNERS; k++)
        begin
            if (!texel_loaded[fp.idx[k]])
                send_load(fp.idx[k], random_texel());
        end
        send_item(FUNC_SAMPLE, INDEX_W'($urandom), random_texel(), u, v);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Wait for all results, then let trailing loads leave the pipeline
    task automatic drain_pipeline();
        idle_for(1);
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == REG_TEX_WIDTH)
            width_reg = data;
        else if (addr == REG_TEX_HEIGHT)
            height_reg = data;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        drain_pipeline();
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input chan_t want, input chan_t got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        texel_t want;
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none actual %0d %0d %0d",
                             $time, red, green, blue);
            end
            else
            begin
                want = expected_colors.pop_front();
                check_field("red", want.red, red);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    initial
    begin : watchdog
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_count = 0;
            else
                stall_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size 256x256: clamped, corner and mid coordinates, color extremes
    task automatic test_edge_coordinates();
        send_load(16'd0, texel_t'(24'h000000));
        send_load(16'hFFFF, texel_t'(24'hFFFFFF));
        send_sample(18'sd0, 18'sd0);
        send_sample(COORD_W'(COORD_ONE), COORD_W'(COORD_ONE));
        send_sample(18'sh20000, 18'sd131071);
        send_sample(18'sd131071, -18'sd1);
        send_sample(COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE / 2));
        send_sample(18'sd1, COORD_W'(COORD_ONE - 1));
    endtask

    // Degenerate and oversize dimensions, spare register slots
    task automatic test_dimension_limits();
        set_dims(9'd0, 9'd0);
        send_sample(COORD_W'(COORD_ONE), -18'sd5);
        send_sample(18'sd12345, COORD_W'(COORD_ONE));
        set_dims(9'd511, 9'd257);
        send_sample(COORD_W'(COORD_ONE), COORD_W'(COORD_ONE));
        set_dims(9'd1, 9'd256);
        send_sample(COORD_W'(COORD_ONE / 3), COORD_W'(COORD_ONE / 5));
        set_dims(9'd2, 9'd2);
        send_sample(COORD_W'(COORD_ONE / 2), COORD_W'(COORD_ONE / 4));
        drain_pipeline();
        write_reg(REG_SPARE_LO, 9'h1FF);
        write_reg(REG_SPARE_HI, 9'h000);
        send_sample(COORD_W'(COORD_ONE - 1), COORD_W'(COORD_ONE / 2));
    endtask

    // Phases of random loads and samples, each at a random texture size
    task automatic test_random_traffic();
        int pick, area, phase_len;
        bit burst;
        logic [CFG_W-1:0] w, h;
        while (item_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                w = CFG_W'($urandom_range(1, 16));
                h = CFG_W'($urandom_range(1, 16));
            end
            else if (pick == 6)
            begin
                w = 9'd256;
                h = CFG_W'($urandom_range(1, 256));
            end
            else if (pick == 7)
            begin
                w = CFG_W'($urandom_range(0, 511));
                h = CFG_W'($urandom_range(0, 511));
            end
            else if (pick == 8)
            begin
                w = ($urandom_range(0, 1) == 0) ? 9'd1 : 9'd3;
                h = ($urandom_range(0, 1) == 0) ? 9'd1 : 9'd4;
            end
            else
            begin
                w = CFG_W'($urandom_range(1, 256));
                h = CFG_W'($urandom_range(1, 256));
            end
            set_dims(w, h);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_W'($urandom));
            area = used_dim(width_reg, DIM_LIMIT_W) * used_dim(height_reg, DIM_LIMIT_H);
            burst = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 200);
            for (int n = 0; n < phase_len && item_count < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_load(INDEX_W'($urandom_range(0, area - 1)), random_texel());
                else if (pick < 30)
                    send_load(INDEX_W'($urandom), random_texel());
                else
                    send_sample(random_coord(), random_coord());
                idle_for(random_gap(burst));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_LOAD;
        texel_index = '0;
        texel_red   = '0;
        texel_green = '0;
        texel_blue  = '0;
        u_coord     = '0;
        v_coord     = '0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_TEX_WIDTH;
        cfg_wdata   = '0;
        width_reg   = TEX_DIM_RESET;
        height_reg  = TEX_DIM_RESET;
        error_count = 0;
        item_count  = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_coordinates();
        test_dimension_limits();
        test_random_traffic();
        drain_pipeline();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/bts_pkg.sv
sv/bts_tex_ram.sv
sv/bts_blend_lane.sv
sv/bilinear_texture_sampler_top.sv
tb/sv/tb_bilinear_texture_sampler_top.sv
